// ----- rtl/core/wsd_pkg.sv -----
// Types, codes and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [3:0] {
        PH_FLAGS   = 4'd0,
        PH_LEN     = 4'd1,
        PH_EXT0    = 4'd2,
        PH_EXT1    = 4'd3,
        PH_EXT2    = 4'd4,
        PH_EXT3    = 4'd5,
        PH_EXT4    = 4'd6,
        PH_EXT5    = 4'd7,
        PH_EXT6    = 4'd8,
        PH_EXT7    = 4'd9,
        PH_KEY0    = 4'd10,
        PH_KEY1    = 4'd11,
        PH_KEY2    = 4'd12,
        PH_KEY3    = 4'd13,
        PH_PAYLOAD = 4'd14
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_RSV        = 3'd1,
        ERR_RSV_OPCODE = 3'd2,
        ERR_UNK_OPCODE = 3'd3,
        ERR_UNMASKED   = 3'd4,
        ERR_STRAY_CONT = 3'd5,
        ERR_DATA_FRAG  = 3'd6
    } err_code_t;

    localparam logic [3:0] OP_CONT     = 4'd0;
    localparam logic [3:0] OP_TEXT     = 4'd1;
    localparam logic [3:0] OP_BINARY   = 4'd2;
    localparam logic [3:0] OP_RSV_LO   = 4'd3;
    localparam logic [3:0] OP_RSV_HI   = 4'd7;
    localparam logic [3:0] OP_CTRL_MAX = 4'd10;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       fin_flag;
        logic       last_of_frame;
        logic       message_done;
        logic [3:0] message_opcode;
        logic       error_flag;
        err_code_t  error_code;
    } result_t;

endpackage

// ----- rtl/core/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
//   channel | signals                          | moves per transfer
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_byte      | one stream byte
//   out     | out_valid, out_ready, fields     | one payload byte, marker or error
//   cfg     | cfg_wr_en, cfg_wr_data           | server_mode, written at once
//
// One byte per cycle unless out_ready holds back a full result register.
// The rate is set by the combinational parser step between input and result registers.
// Header bytes that yield no result (no error, no empty-frame end) pass even while the result register is full.
// After an error result every further byte is taken and dropped until reset.
// rst_n clears all control state asynchronously; no clearing pass is needed.
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic [3:0] frame_opcode,
    output logic       fin_flag,
    output logic       last_of_frame,
    output logic       message_done,
    output logic [3:0] message_opcode,
    output logic       error_flag,
    output logic [2:0] error_code
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       emit;
    logic       advance;
    result_t    res_new;
    result_t    res_out;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .byte_in     (s1_byte_reg),
        .emit        (emit),
        .result      (res_new)
    );

    wsd_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance && emit),
        .res_in  (res_new),
        .ready   (out_ready),
        .valid   (out_valid),
        .res_out (res_out)
    );

    assign advance  = s1_valid_reg && (!out_valid || out_ready || !emit);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    assign data_byte      = res_out.data_byte;
    assign has_data       = res_out.has_data;
    assign frame_opcode   = res_out.frame_opcode;
    assign fin_flag       = res_out.fin_flag;
    assign last_of_frame  = res_out.last_of_frame;
    assign message_done   = res_out.message_done;
    assign message_opcode = res_out.message_opcode;
    assign error_flag     = res_out.error_flag;
    assign error_code     = res_out.error_code;

`ifndef SYNTHESIS
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_flag) |-> (!has_data && !last_of_frame && !message_done))
        else $error("error result carries data or frame markers");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_done) |-> last_of_frame)
        else $error("message end without frame end");

    a_silent_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && error_flag) |=> !out_valid)
        else $error("result after an error result");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid && !out_ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ----- rtl/core/wsd_parser.sv -----
// Frame parser: header state, length, masking key and fragmentation tracking.
// Depends on wsd_pkg; one byte is processed per step pulse.
`timescale 1ns / 1ps

module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       step,
    input  logic [7:0] byte_in,
    output logic       emit,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic        mask_reg, mask_next;
    logic [63:0] pay_reg, pay_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        frag_reg, frag_next;
    logic [3:0]  frag_op_reg, frag_op_next;
    logic        stop_reg, stop_next;
    logic        server_mode_reg;

    logic [3:0]  op_b;
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [63:0] pay_shift;
    logic [63:0] pay_dec;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic        hd_go;
    logic        hd_mask;
    logic [63:0] hd_pay;
    logic        ef_go;
    logic [7:0]  ef_data;
    logic        ef_has;
    logic        err_go;
    err_code_t   err_code;
    logic        dat_go;
    logic [3:0]  msg_op;

    assign op_b      = byte_in[3:0];
    assign op        = flags_reg[3:0];
    assign len7      = byte_in[6:0];
    assign pay_shift = {pay_reg[55:0], byte_in};
    assign pay_dec   = pay_reg - 64'd1;
    assign key_byte  = mask_reg ? 8'(key_reg >> {~idx_reg, 3'b000}) : 8'h00;
    assign plain     = byte_in ^ key_byte;

    always_comb
    begin
        if ((op == OP_TEXT) || (op == OP_BINARY))
        begin
            msg_op = op;
        end
        else if (op == OP_CONT)
        begin
            msg_op = frag_op_reg;
        end
        else
        begin
            msg_op = 4'd0;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        mask_next    = mask_reg;
        pay_next     = pay_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        frag_next    = frag_reg;
        frag_op_next = frag_op_reg;
        stop_next    = stop_reg;
        hd_go        = 1'b0;
        hd_mask      = mask_reg;
        hd_pay       = pay_reg;
        ef_go        = 1'b0;
        ef_data      = 8'h00;
        ef_has       = 1'b0;
        err_go       = 1'b0;
        err_code     = ERR_NONE;
        dat_go       = 1'b0;

        case (phase_reg)
            PH_FLAGS:
            begin
                flags_next = byte_in;
                if (byte_in[6:4] != 3'd0)
                begin
                    err_go   = 1'b1;
                    err_code = ERR_RSV;
                end
                else if (op_b inside {[OP_RSV_LO:OP_RSV_HI]})
                begin
                    err_go   = 1'b1;
                    err_code = ERR_RSV_OPCODE;
                end
                else if (op_b > OP_CTRL_MAX)
                begin
                    err_go   = 1'b1;
                    err_code = ERR_UNK_OPCODE;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                mask_next = byte_in[7];
                if (server_mode_reg && !byte_in[7])
                begin
                    err_go   = 1'b1;
                    err_code = ERR_UNMASKED;
                end
                else if ((op == OP_CONT) && !frag_reg)
                begin
                    err_go   = 1'b1;
                    err_code = ERR_STRAY_CONT;
                end
                else if (((op == OP_TEXT) || (op == OP_BINARY)) && frag_reg)
                begin
                    err_go   = 1'b1;
                    err_code = ERR_DATA_FRAG;
                end
                else
                begin
                    key_next = 32'd0;
                    if (len7 == LEN7_EXT16)
                    begin
                        pay_next   = 64'd0;
                        phase_next = PH_EXT6;
                    end
                    else if (len7 == LEN7_EXT64)
                    begin
                        pay_next   = 64'd0;
                        phase_next = PH_EXT0;
                    end
                    else
                    begin
                        pay_next = {57'd0, len7};
                        hd_go    = 1'b1;
                        hd_mask  = byte_in[7];
                        hd_pay   = {57'd0, len7};
                    end
                end
            end
            PH_EXT0, PH_EXT1, PH_EXT2, PH_EXT3, PH_EXT4, PH_EXT5, PH_EXT6, PH_EXT7:
            begin
                pay_next = pay_shift;
                if (phase_reg == PH_EXT7)
                begin
                    hd_go  = 1'b1;
                    hd_pay = pay_shift;
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3:
            begin
                key_next = {key_reg[23:0], byte_in};
                if (phase_reg == PH_KEY3)
                begin
                    idx_next = 2'd0;
                    if (pay_reg == 64'd0)
                    begin
                        ef_go = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_PAYLOAD:
            begin
                idx_next = idx_reg + 2'd1;
                pay_next = pay_dec;
                if (pay_dec == 64'd0)
                begin
                    ef_go   = 1'b1;
                    ef_data = plain;
                    ef_has  = 1'b1;
                end
                else
                begin
                    dat_go = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_FLAGS;
            end
        endcase

        if (hd_go)
        begin
            if (hd_mask)
            begin
                phase_next = PH_KEY0;
            end
            else
            begin
                idx_next = 2'd0;
                if (hd_pay == 64'd0)
                begin
                    ef_go = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        if (ef_go)
        begin
            phase_next = PH_FLAGS;
            if ((op == OP_CONT) && flags_reg[7])
            begin
                frag_next    = 1'b0;
                frag_op_next = 4'd0;
            end
            else if (((op == OP_TEXT) || (op == OP_BINARY)) && !flags_reg[7])
            begin
                frag_next    = 1'b1;
                frag_op_next = op;
            end
        end

        if (err_go)
        begin
            stop_next = 1'b1;
        end
    end

    always_comb
    begin
        result                = '0;
        result.frame_opcode   = flags_next[3:0];
        result.fin_flag       = flags_next[7];
        result.error_code     = ERR_NONE;
        if (err_go)
        begin
            result.error_flag = 1'b1;
            result.error_code = err_code;
        end
        else if (ef_go)
        begin
            result.data_byte      = ef_data;
            result.has_data       = ef_has;
            result.last_of_frame  = 1'b1;
            result.message_done   = (op <= OP_BINARY) && flags_reg[7];
            result.message_opcode = msg_op;
        end
        else if (dat_go)
        begin
            result.data_byte      = plain;
            result.has_data       = 1'b1;
            result.message_opcode = msg_op;
        end
    end

    assign emit = !stop_reg && (err_go || ef_go || dat_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            server_mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FLAGS;
            flags_reg   <= 8'd0;
            mask_reg    <= 1'b0;
            pay_reg     <= 64'd0;
            key_reg     <= 32'd0;
            idx_reg     <= 2'd0;
            frag_reg    <= 1'b0;
            frag_op_reg <= 4'd0;
            stop_reg    <= 1'b0;
        end
        else if (step && !stop_reg)
        begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            mask_reg    <= mask_next;
            pay_reg     <= pay_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            frag_reg    <= frag_next;
            frag_op_reg <= frag_op_next;
            stop_reg    <= stop_next;
        end
    end

endmodule

// ----- rtl/core/wsd_out_reg.sv -----
// Result register: holds one result until the downstream transfer.
// Depends on wsd_pkg for the result struct.
`timescale 1ns / 1ps

module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    ready,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule
